/* rtl/fpa_pkg.sv */
// Shared types, constants and helper functions of the fixed-point ALU.
// No dependencies.
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_W = 32;
	localparam int DIV_STAGES = 32;

	typedef enum logic [3:0] {
		MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
		MODE_GT = 4'd4, MODE_LT = 4'd5, MODE_GE = 4'd6, MODE_LE = 4'd7,
		MODE_EQ = 4'd8, MODE_NE = 4'd9, MODE_MIN = 4'd10, MODE_MAX = 4'd11,
		MODE_INC = 4'd12, MODE_DEC = 4'd13, MODE_TOINT = 4'd14, MODE_FROMINT = 4'd15
	} mode_t;

	// Per-transaction side information that rides along with the divider.
	typedef struct packed {
		logic                is_div;
		logic                neg;
		logic                ovf;
		logic                dz;
		logic [WORD_W-1:0]   res;
		logic                cmp;
		logic                sat;
	} meta_t;

	// Clamp a 33-bit signed value to the word range: {sat, word}.
	function automatic logic [WORD_W:0] sat33(input logic [WORD_W:0] v);
		logic [WORD_W:0] r;
		case (v[WORD_W:WORD_W-1])
			2'b01:   r = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
			2'b10:   r = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
			default: r = {1'b0, v[WORD_W-1:0]};
		endcase
		return r;
	endfunction

	// Apply a sign to a magnitude with clamping: {sat, word}.
	function automatic logic [WORD_W:0] sclamp(input logic [63:0] m, input logic neg);
		logic [WORD_W:0] r;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000)
				r = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
			else
				r = {1'b0, 32'(-m)};
		end else begin
			if (m > 64'h0000_0000_7FFF_FFFF)
				r = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
			else
				r = {1'b0, m[WORD_W-1:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/fpa_front.sv */
// Front end of the fixed-point ALU: decode, simple ops, multiply, divide prep.
// Three pipeline stages. Depends on fpa_pkg.
module fpa_front #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [3:0]          mode,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                out_valid,
	output fpa_pkg::meta_t      out_meta,
	output logic [32:0]         out_rem,
	output logic [31:0]         out_num_lo,
	output logic [32:0]         out_den
);

	localparam int NW = 34 + FRAC_BITS;

	fpa_pkg::mode_t  mode_c;
	logic [31:0]     mag_a, mag_b, ma_sh;
	logic [32:0]     sum_c, diff_c, inc_c, dec_c;
	logic signed [63:0] fi_c;
	logic            lt_c, eq_c;
	fpa_pkg::meta_t  meta_c;

	logic            valid_s1, is_mul_s1;
	fpa_pkg::meta_t  meta_s1;
	logic [31:0]     mag_a_s1, mag_b_s1;

	logic            valid_s2, is_mul_s2;
	fpa_pkg::meta_t  meta_s2;
	logic [63:0]     prod_s2;
	logic [NW-1:0]   num_s2;
	logic [32:0]     den_s2;

	logic [63:0]     half_c, mround_c;
	logic [32:0]     mres_c;
	logic [NW-1:0]   hi_c;
	fpa_pkg::meta_t  meta3_c;

	always_comb begin
		mode_c = fpa_pkg::mode_t'(mode);
		mag_a  = operand_a[31] ? 32'(-operand_a) : operand_a;
		mag_b  = operand_b[31] ? 32'(-operand_b) : operand_b;
		ma_sh  = mag_a >> FRAC_BITS;
		sum_c  = 33'({operand_a[31], operand_a} + {operand_b[31], operand_b});
		diff_c = 33'({operand_a[31], operand_a} - {operand_b[31], operand_b});
		inc_c  = 33'({operand_a[31], operand_a} + 33'd1);
		dec_c  = 33'({operand_a[31], operand_a} - 33'd1);
		fi_c   = 64'(operand_a) <<< FRAC_BITS;
		lt_c   = operand_a < operand_b;
		eq_c   = operand_a == operand_b;

		meta_c        = '0;
		meta_c.neg    = operand_a[31] ^ operand_b[31];
		case (mode_c)
			fpa_pkg::MODE_ADD: {meta_c.sat, meta_c.res} = fpa_pkg::sat33(sum_c);
			fpa_pkg::MODE_SUB: {meta_c.sat, meta_c.res} = fpa_pkg::sat33(diff_c);
			fpa_pkg::MODE_MUL: meta_c.res = '0;
			fpa_pkg::MODE_DIV: begin
				meta_c.is_div = operand_b != 0;
				meta_c.dz     = operand_b == 0;
			end
			fpa_pkg::MODE_GT:  meta_c.cmp = !lt_c && !eq_c;
			fpa_pkg::MODE_LT:  meta_c.cmp = lt_c;
			fpa_pkg::MODE_GE:  meta_c.cmp = !lt_c;
			fpa_pkg::MODE_LE:  meta_c.cmp = lt_c || eq_c;
			fpa_pkg::MODE_EQ:  meta_c.cmp = eq_c;
			fpa_pkg::MODE_NE:  meta_c.cmp = !eq_c;
			fpa_pkg::MODE_MIN: meta_c.res = lt_c ? operand_a : operand_b;
			fpa_pkg::MODE_MAX: meta_c.res = lt_c ? operand_b : operand_a;
			fpa_pkg::MODE_INC: {meta_c.sat, meta_c.res} = fpa_pkg::sat33(inc_c);
			fpa_pkg::MODE_DEC: {meta_c.sat, meta_c.res} = fpa_pkg::sat33(dec_c);
			fpa_pkg::MODE_TOINT: meta_c.res = operand_a[31] ? 32'(-ma_sh) : ma_sh;
			default: begin
				if (fi_c > 64'sh0000_0000_7FFF_FFFF) begin
					meta_c.sat = 1'b1;
					meta_c.res = 32'h7FFF_FFFF;
				end else if (fi_c < -64'sh0000_0000_8000_0000) begin
					meta_c.sat = 1'b1;
					meta_c.res = 32'h8000_0000;
				end else begin
					meta_c.res = fi_c[31:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1   <= meta_c;
		is_mul_s1 <= mode_c == fpa_pkg::MODE_MUL;
		mag_a_s1  <= mag_a;
		mag_b_s1  <= mag_b;

		meta_s2   <= meta_s1;
		is_mul_s2 <= is_mul_s1;
		prod_s2   <= 64'(mag_a_s1) * 64'(mag_b_s1);
		// divide operands: (2*|a|*2^F + |b|) / (2*|b|)
		num_s2    <= (NW'(mag_a_s1) << (FRAC_BITS + 1)) + NW'(mag_b_s1);
		den_s2    <= {mag_b_s1, 1'b0};

		out_meta   <= meta3_c;
		out_rem    <= hi_c[32:0];
		out_num_lo <= num_s2[31:0];
		out_den    <= den_s2;
	end

	always_comb begin
		half_c   = (64'd1 << FRAC_BITS) >> 1;
		mround_c = (prod_s2 + half_c) >> FRAC_BITS;
		mres_c   = fpa_pkg::sclamp(mround_c, meta_s2.neg);
		hi_c     = num_s2 >> 32;
		meta3_c  = meta_s2;
		// quotient needs more than 32 bits
		meta3_c.ovf = hi_c >= NW'(den_s2);
		if (is_mul_s2)
			{meta3_c.sat, meta3_c.res} = mres_c;
	end

endmodule

/* rtl/fpa_div.sv */
// Pipelined restoring divider, one quotient bit per stage, meta carried along.
// Depends on fpa_pkg.
module fpa_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  fpa_pkg::meta_t  in_meta,
	input  logic [32:0]     in_rem,
	input  logic [31:0]     in_num_lo,
	input  logic [32:0]     in_den,
	output logic            out_valid,
	output fpa_pkg::meta_t  out_meta,
	output logic [31:0]     out_quot
);

	localparam int N = fpa_pkg::DIV_STAGES;

	logic            valid_s [N+1];
	fpa_pkg::meta_t  meta_s  [N+1];
	logic [32:0]     rem_s   [N+1];
	logic [31:0]     lo_s    [N+1];
	logic [32:0]     den_s   [N+1];
	logic [31:0]     quot_s  [N+1];

	always_comb begin
		valid_s[0] = in_valid;
		meta_s[0]  = in_meta;
		rem_s[0]   = in_rem;
		lo_s[0]    = in_num_lo;
		den_s[0]   = in_den;
		quot_s[0]  = '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [33:0] trial;
		logic        ge;
		always_comb begin
			trial = {rem_s[k], lo_s[k][31]};
			ge    = trial >= {1'b0, den_s[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end
		always_ff @(posedge clk) begin
			meta_s[k+1] <= meta_s[k];
			rem_s[k+1]  <= ge ? 33'(trial - {1'b0, den_s[k]}) : trial[32:0];
			lo_s[k+1]   <= {lo_s[k][30:0], 1'b0};
			den_s[k+1]  <= den_s[k];
			quot_s[k+1] <= {quot_s[k][30:0], ge};
		end
	end

	assign out_valid = valid_s[N];
	assign out_meta  = meta_s[N];
	assign out_quot  = quot_s[N];

endmodule

/* rtl/fixed_point_alu_top.sv */
// Throughput: one transaction per cycle; busy stays low, the 32-stage divider sets latency.
// Reset: arst_n clears all valid bits asynchronously; in-flight transactions are dropped.
// The receiver cannot stall; each result shows for one cycle with done.
// Top level of the fixed-point ALU. Depends on fpa_pkg, fpa_front, fpa_div.
module fixed_point_alu_top #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         mode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               done,
	output logic signed [31:0] result_word,
	output logic               compare_true,
	output logic               divide_by_zero,
	output logic               saturated
);

	logic            f_valid, d_valid;
	fpa_pkg::meta_t  f_meta, d_meta;
	logic [32:0]     f_rem, f_den;
	logic [31:0]     f_lo, d_quot;
	logic [32:0]     qres_c;
	logic [31:0]     res_c;
	logic            sat_c;

	assign busy = 1'b0;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(start && !busy), .mode, .operand_a, .operand_b,
		.out_valid(f_valid), .out_meta(f_meta), .out_rem(f_rem),
		.out_num_lo(f_lo), .out_den(f_den)
	);

	fpa_div u_div (
		.clk, .arst_n,
		.in_valid(f_valid), .in_meta(f_meta), .in_rem(f_rem),
		.in_num_lo(f_lo), .in_den(f_den),
		.out_valid(d_valid), .out_meta(d_meta), .out_quot(d_quot)
	);

	always_comb begin
		qres_c = fpa_pkg::sclamp(64'(d_quot), d_meta.neg);
		res_c  = d_meta.res;
		sat_c  = d_meta.sat;
		if (d_meta.is_div) begin
			if (d_meta.ovf) begin
				sat_c = 1'b1;
				res_c = d_meta.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				{sat_c, res_c} = qres_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_word    <= res_c;
		compare_true   <= d_meta.cmp;
		divide_by_zero <= d_meta.dz;
		saturated      <= sat_c;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##36 done) else $error("transaction lost in pipeline");
	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> result_word == 0 && !saturated && !compare_true)
		else $error("divide by zero result not clean");
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && compare_true |-> result_word == 0 && !saturated && !divide_by_zero)
		else $error("compare result not clean");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for fixed_point_alu_top: directed and random ALU transactions.
// Depends on fpa_pkg and the RTL of the fixed-point ALU.
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = 36;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [31:0] word;
		logic cmp;
		logic dz;
		logic sat;
	} alu_out_t;

	class alu_scoreboard;
		alu_out_t pending[$];
		int errors = 0;
		int checked = 0;

		function automatic logic [63:0] mag(longint v);
			return (v < 0) ? 64'(-v) : 64'(v);
		endfunction

		function automatic void clamp(longint v, ref alu_out_t r);
			if (v > 64'sd2147483647) begin
				r.word = 32'sh7FFFFFFF; r.sat = 1;
			end else if (v < -64'sd2147483648) begin
				r.word = 32'sh80000000; r.sat = 1;
			end else
				r.word = 32'(v);
		endfunction

		function automatic void sign_clamp(logic [63:0] m, logic neg, ref alu_out_t r);
			if (neg) begin
				if (m > 64'h8000_0000) begin
					r.word = 32'sh80000000; r.sat = 1;
				end else
					r.word = 32'(-m);
			end else begin
				if (m > 64'h7FFF_FFFF) begin
					r.word = 32'sh7FFFFFFF; r.sat = 1;
				end else
					r.word = m[31:0];
			end
		endfunction

		function void note_operation(fpa_pkg::mode_t op, logic signed [31:0] a,
				logic signed [31:0] b);
			alu_out_t r;
			longint la, lb;
			logic [63:0] m, na, nb;
			la = a; lb = b;
			r = '{word: 0, cmp: 0, dz: 0, sat: 0};
			case (op)
				fpa_pkg::MODE_ADD: clamp(la + lb, r);
				fpa_pkg::MODE_SUB: clamp(la - lb, r);
				fpa_pkg::MODE_MUL: begin
					m = mag(la) * mag(lb);
					m = (m + ((64'd1 << FRAC) >> 1)) >> FRAC;
					sign_clamp(m, (la < 0) != (lb < 0), r);
				end
				fpa_pkg::MODE_DIV: begin
					if (lb == 0)
						r.dz = 1;
					else begin
						na = mag(la) << FRAC;
						nb = mag(lb);
						sign_clamp((2 * na + nb) / (2 * nb), (la < 0) != (lb < 0), r);
					end
				end
				fpa_pkg::MODE_GT: r.cmp = la > lb;
				fpa_pkg::MODE_LT: r.cmp = la < lb;
				fpa_pkg::MODE_GE: r.cmp = la >= lb;
				fpa_pkg::MODE_LE: r.cmp = la <= lb;
				fpa_pkg::MODE_EQ: r.cmp = la == lb;
				fpa_pkg::MODE_NE: r.cmp = la != lb;
				fpa_pkg::MODE_MIN: r.word = (la < lb) ? a : b;
				fpa_pkg::MODE_MAX: r.word = (la > lb) ? a : b;
				fpa_pkg::MODE_INC: clamp(la + 1, r);
				fpa_pkg::MODE_DEC: clamp(la - 1, r);
				// truncation toward zero
				fpa_pkg::MODE_TOINT: r.word = 32'(la / (64'sd1 <<< FRAC));
				default: clamp(la * (64'sd1 <<< FRAC), r);
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] w, logic c, logic d, logic s);
			alu_out_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word=%0d cmp=%0b dz=%0b sat=%0b",
					$time, w, c, d, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (w !== e.word) begin
				$display("%0t: result_word expected %0d actual %0d", $time, e.word, w);
				errors++;
			end
			if (c !== e.cmp) begin
				$display("%0t: compare_true expected %0b actual %0b", $time, e.cmp, c);
				errors++;
			end
			if (d !== e.dz) begin
				$display("%0t: divide_by_zero expected %0b actual %0b", $time, e.dz, d);
				errors++;
			end
			if (s !== e.sat) begin
				$display("%0t: saturated expected %0b actual %0b", $time, e.sat, s);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [3:0] mode = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic busy, done, compare_true, divide_by_zero, saturated;
	logic signed [31:0] result_word;

	alu_scoreboard alu_sb = new();
	int cycles = 0;
	bit no_gaps = 0;

	always #10 clk = ~clk;

	fixed_point_alu_top #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result_word(result_word), .compare_true(compare_true),
		.divide_by_zero(divide_by_zero), .saturated(saturated)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done)
			alu_sb.check_result(result_word, compare_true, divide_by_zero, saturated);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drive one transaction; start stays high across back-to-back issues.
	task automatic issue_op(fpa_pkg::mode_t op, logic signed [31:0] a, logic signed [31:0] b);
		int gap;
		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			start <= 0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		mode <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		alu_sb.note_operation(op, a, b);
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFFFFFF - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 1024)) - 512;
			3: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic signed [31:0] a, b;
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int m = 0; m < 16; m++)
			issue_op(fpa_pkg::mode_t'(m), 32'sh0000_0380, -32'sh0000_0140);
		issue_op(fpa_pkg::MODE_ADD, 32'sh7FFFFFFF, 32'sh1);
		issue_op(fpa_pkg::MODE_SUB, 32'sh80000000, 32'sh1);
		issue_op(fpa_pkg::MODE_MUL, 32'sh7FFFFFFF, 32'sh80000000);
		issue_op(fpa_pkg::MODE_MUL, 32'sh0000_0080, 32'sh0000_0001);
		issue_op(fpa_pkg::MODE_DIV, 32'sh1234, 32'sh0);
		issue_op(fpa_pkg::MODE_DIV, 32'sh80000000, 32'sh1);
		issue_op(fpa_pkg::MODE_INC, 32'sh7FFFFFFF, 32'sh0);
		issue_op(fpa_pkg::MODE_DEC, 32'sh80000000, 32'sh0);
		issue_op(fpa_pkg::MODE_TOINT, -32'sh0000_01FF, 32'sh0);
		issue_op(fpa_pkg::MODE_FROMINT, 32'sh00800000, 32'sh0);
		issue_op(fpa_pkg::MODE_MIN, 32'sh55, 32'sh55);

		for (int i = 0; i < 650; i++) begin
			no_gaps = (i >= 550);
			a = pick_word();
			b = ($urandom_range(0, 9) == 0) ? a : pick_word();
			if ($urandom_range(0, 15) == 0) b = 0;
			issue_op(fpa_pkg::mode_t'($urandom_range(0, 15)), a, b);
		end
		start <= 0;

		while (alu_sb.pending.size() != 0) @(posedge clk);
		waited = 0;
		while (waited < LATENCY + 4) begin
			@(posedge clk);
			waited++;
		end
		$display("checked %0d ALU transactions over all 16 modes,", alu_sb.checked);
		$display("incl. saturation, divide by zero and back-to-back issue");
		if (alu_sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_top.sv
verif/tb_top.sv
